@@ hdl/redundant_sensor_outlier_vote_unit_defines.svh @@
// Assertion macros for the outlier vote unit checker.
// No dependencies; expects i_clk and i_rst_n in the including scope.
`ifndef REDUNDANT_SENSOR_OUTLIER_VOTE_UNIT_DEFINES_SVH
`define REDUNDANT_SENSOR_OUTLIER_VOTE_UNIT_DEFINES_SVH

// same-cycle implication
`define RSOV_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RSOV_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/rsov_pkg.sv @@
// Shared types and constants for the redundant sensor outlier vote unit.
// No dependencies.
package rsov_pkg;

    localparam int SENSOR_SLOTS = 4;
    localparam int NUM_SENSORS  = 4;
    localparam int TEMP_BITS    = 16;
    localparam int THR_BITS     = 16;
    localparam int CNT_BITS     = 3;

    localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(32);

    typedef enum logic [1:0] {
        ST_AVERAGED     = 2'd0,
        ST_SINGLE       = 2'd1,
        ST_ALL_OUTLIERS = 2'd2,
        ST_NONE_VALID   = 2'd3
    } t_vote_status;

    typedef struct packed {
        logic signed [TEMP_BITS-1:0] temp_0;
        logic signed [TEMP_BITS-1:0] temp_1;
        logic signed [TEMP_BITS-1:0] temp_2;
        logic signed [TEMP_BITS-1:0] temp_3;
        logic                        fault_0;
        logic                        fault_1;
        logic                        fault_2;
        logic                        fault_3;
    } t_item_in;

    typedef struct packed {
        logic signed [TEMP_BITS-1:0] fused_temp;
        logic [CNT_BITS-1:0]         valid_count;
        logic [SENSOR_SLOTS-1:0]     outlier_mask;
        t_vote_status                vote_status;
    } t_result;

    typedef struct packed {
        logic load;
        logic sum;
        logic eval;
        logic decide;
        logic div_abs;
        logic div_mul;
        logic div_fix;
    } t_dp_cmd;

    typedef struct packed {
        logic few_valid;  // fewer than two readings take part
        logic reject;     // worst reading is at or beyond threshold
        logic last;       // a rejection now leaves one reading
    } t_dp_sts;

endpackage

@@ hdl/rsov_ctrl.sv @@
// Sequencer for the outlier vote: one-hot state machine issuing datapath commands.
// Depends on rsov_pkg.
module rsov_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  rsov_pkg::t_dp_sts i_sts,
    output rsov_pkg::t_dp_cmd o_cmd,
    output logic              o_busy,
    output logic              o_strobe
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_SUM     = 8'b0000_0010,
        S_EVAL    = 8'b0000_0100,
        S_DECIDE  = 8'b0000_1000,
        S_DIV_ABS = 8'b0001_0000,
        S_DIV_MUL = 8'b0010_0000,
        S_DIV_FIX = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                n_state = i_sts.few_valid ? S_DONE : S_EVAL;
            end
            S_EVAL: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                priority if (i_sts.reject && i_sts.last) begin
                    n_state = S_DONE;
                end else if (i_sts.reject) begin
                    n_state = S_EVAL;
                end else begin
                    n_state = S_DIV_ABS;
                end
            end
            S_DIV_ABS: begin
                n_state = S_DIV_MUL;
            end
            S_DIV_MUL: begin
                n_state = S_DIV_FIX;
            end
            S_DIV_FIX: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd.load    = (r_state == S_IDLE) && i_start;
        o_cmd.sum     = (r_state == S_SUM);
        o_cmd.eval    = (r_state == S_EVAL);
        o_cmd.decide  = (r_state == S_DECIDE);
        o_cmd.div_abs = (r_state == S_DIV_ABS);
        o_cmd.div_mul = (r_state == S_DIV_MUL);
        o_cmd.div_fix = (r_state == S_DIV_FIX);
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = (r_state == S_DONE);

endmodule

@@ hdl/rsov_datapath.sv @@
// Datapath for the outlier vote: readings, running sum, deviations, rejection
// and the divide by count. Depends on rsov_pkg.
module rsov_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rsov_pkg::t_item_in               i_item,
    input  logic                             i_cfg_we,
    input  logic [rsov_pkg::THR_BITS-1:0]    i_cfg_wdata,
    input  rsov_pkg::t_dp_cmd                i_cmd,
    output rsov_pkg::t_dp_sts                o_sts,
    output rsov_pkg::t_result                o_result
);

    localparam int SLOTS  = rsov_pkg::SENSOR_SLOTS;
    localparam int TB     = rsov_pkg::TEMP_BITS;
    localparam int CB     = rsov_pkg::CNT_BITS;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int SUM_W  = TB + 2;
    localparam int DEV_W  = TB + 4;
    localparam int THRN_W = rsov_pkg::THR_BITS + CB;
    localparam int CMP_W  = (DEV_W > THRN_W) ? DEV_W : THRN_W;
    localparam int MAG_W  = SUM_W;
    localparam int PROD_W = 2 * MAG_W - 1;
    // floor(2^MAG_W / 3): quotient low by at most one, fixed in the last step
    localparam logic [MAG_W-2:0] RECIP3 = (MAG_W-1)'((64'd1 << MAG_W) / 64'd3);

    logic signed [TB-1:0]         r_temp [SLOTS];
    logic [SLOTS-1:0]             r_live;
    logic signed [SUM_W-1:0]      r_sum;
    logic [CB-1:0]                r_cnt;
    logic [SLOTS-1:0]             r_rej;
    logic signed [TB-1:0]         r_fused;
    rsov_pkg::t_vote_status       r_status;
    logic [DEV_W-1:0]             r_dev [SLOTS];
    logic [THRN_W-1:0]            r_thr_n;
    logic [rsov_pkg::THR_BITS-1:0] r_thr;
    logic                         r_neg;
    logic [MAG_W-1:0]             r_mag;
    logic [MAG_W-1:0]             r_q0;

    logic signed [TB-1:0]    in_temp [SLOTS];
    logic [SLOTS-1:0]        in_fault;
    logic [CB-1:0]           live_cnt;
    logic signed [SUM_W-1:0] sum_all;
    logic signed [TB-1:0]    single_val;
    logic [DEV_W-1:0]        n_dev [SLOTS];
    logic [IDX_W-1:0]        worst_idx;
    logic [DEV_W-1:0]        worst_dev;
    logic                    do_reject;
    logic [SLOTS-1:0]        survivors;
    logic signed [TB-1:0]    survivor_val;
    logic [PROD_W-1:0]       prod3;
    logic [MAG_W-1:0]        n_q0;
    logic [MAG_W-1:0]        q_back;
    logic [MAG_W-1:0]        q_rem;
    logic [MAG_W-1:0]        q_fix;
    logic signed [TB-1:0]    avg_val;

    assign in_temp[0]  = i_item.temp_0;
    assign in_temp[1]  = i_item.temp_1;
    assign in_temp[2]  = i_item.temp_2;
    assign in_temp[3]  = i_item.temp_3;
    assign in_fault    = {i_item.fault_3, i_item.fault_2, i_item.fault_1, i_item.fault_0};

    // participation count, sum and the lone reading
    always_comb begin
        live_cnt   = '0;
        sum_all    = '0;
        single_val = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (r_live[i]) begin
                live_cnt   = live_cnt + CB'(1);
                sum_all    = sum_all + SUM_W'(r_temp[i]);
                single_val = r_temp[i];
            end
        end
    end

    // |n*x - S| for every reading
    always_comb begin
        logic signed [DEV_W-1:0] cnt_s;
        logic signed [DEV_W-1:0] diff;
        cnt_s = DEV_W'($signed({1'b0, r_cnt}));
        for (int i = 0; i < SLOTS; i++) begin
            diff     = cnt_s * DEV_W'(r_temp[i]) - DEV_W'(r_sum);
            n_dev[i] = diff[DEV_W-1] ? DEV_W'(-diff) : DEV_W'(diff);
        end
    end

    // farthest live reading, lowest index on ties
    always_comb begin
        logic found;
        found     = 1'b0;
        worst_idx = '0;
        worst_dev = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (r_live[i] && (!found || (r_dev[i] > worst_dev))) begin
                found     = 1'b1;
                worst_idx = IDX_W'(i);
                worst_dev = r_dev[i];
            end
        end
    end

    assign do_reject = CMP_W'(worst_dev) >= CMP_W'(r_thr_n);
    assign survivors = r_live & ~(SLOTS'(1) << worst_idx);

    always_comb begin
        survivor_val = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (survivors[i]) begin
                survivor_val = r_temp[i];
            end
        end
    end

    // divide by count: shift for two and four, reciprocal for three
    assign prod3 = PROD_W'(r_mag) * PROD_W'(RECIP3);

    always_comb begin
        unique case (r_cnt)
            CB'(3):  n_q0 = MAG_W'(prod3[PROD_W-1:MAG_W]);
            CB'(4):  n_q0 = r_mag >> 2;
            default: n_q0 = r_mag >> 1;
        endcase
    end

    assign q_back  = r_q0 * MAG_W'(r_cnt);
    assign q_rem   = r_mag - q_back;
    assign q_fix   = (q_rem >= MAG_W'(r_cnt)) ? r_q0 + MAG_W'(1) : r_q0;
    assign avg_val = r_neg ? TB'(MAG_W'(0) - q_fix) : TB'(q_fix);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= rsov_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_temp[i] <= in_temp[i];
                r_live[i] <= !in_fault[i] && (i < rsov_pkg::NUM_SENSORS);
            end
        end
        if (i_cmd.sum) begin
            r_sum <= sum_all;
            r_cnt <= live_cnt;
            r_rej <= '0;
            priority if (live_cnt == CB'(0)) begin
                r_fused  <= '0;
                r_status <= rsov_pkg::ST_NONE_VALID;
            end else if (live_cnt == CB'(1)) begin
                r_fused  <= single_val;
                r_status <= rsov_pkg::ST_SINGLE;
            end else begin
                r_status <= rsov_pkg::ST_AVERAGED;
            end
        end
        if (i_cmd.eval) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_dev[i] <= n_dev[i];
            end
            r_thr_n <= THRN_W'(r_thr) * THRN_W'(r_cnt);
        end
        if (i_cmd.decide && do_reject) begin
            if (r_cnt == CB'(2)) begin
                // only one left: it goes out as well, marked
                r_rej    <= r_rej | r_live;
                r_live   <= '0;
                r_cnt    <= '0;
                r_fused  <= survivor_val;
                r_status <= rsov_pkg::ST_ALL_OUTLIERS;
            end else begin
                r_live[worst_idx] <= 1'b0;
                r_rej[worst_idx]  <= 1'b1;
                r_sum             <= r_sum - SUM_W'(r_temp[worst_idx]);
                r_cnt             <= r_cnt - CB'(1);
            end
        end
        if (i_cmd.div_abs) begin
            r_neg <= r_sum[SUM_W-1];
            r_mag <= r_sum[SUM_W-1] ? MAG_W'(-r_sum) : MAG_W'(r_sum);
        end
        if (i_cmd.div_mul) begin
            r_q0 <= n_q0;
        end
        if (i_cmd.div_fix) begin
            r_fused <= avg_val;
        end
    end

    always_comb begin
        o_sts.few_valid = (live_cnt < CB'(2));
        o_sts.reject    = do_reject;
        o_sts.last      = (r_cnt == CB'(2));
    end

    always_comb begin
        o_result.fused_temp   = r_fused;
        o_result.valid_count  = r_cnt;
        o_result.outlier_mask = r_rej;
        o_result.vote_status  = r_status;
    end

endmodule

@@ hdl/redundant_sensor_outlier_vote_unit.sv @@
// Top level of the redundant sensor outlier vote unit.
// Depends on rsov_pkg, rsov_ctrl and rsov_datapath.
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------
//  item in  | start, busy        | i_item  (rsov_pkg::t_item_in)
//  result   | o_valid (strobe)   | o_result (rsov_pkg::t_result)
//  config   | i_cfg_we           | i_cfg_wdata (threshold)
//
// An item is taken when start is high and busy low; one item is in work at a time.
// With fewer than two valid readings the strobe follows the sum step directly; otherwise
// it follows R evaluate/decide rounds, R at most three, and for an averaged result also
// the abs, multiply and fix steps of the divide. Busy drops in the cycle after the strobe,
// when the unit is back in idle. Synchronous active-low reset returns to idle, threshold 32.
// The result is shown for one cycle only; the receiver cannot stall it.
module redundant_sensor_outlier_vote_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  rsov_pkg::t_item_in            i_item,
    input  logic                          i_cfg_we,
    input  logic [rsov_pkg::THR_BITS-1:0] i_cfg_wdata,
    output logic                          o_valid,
    output rsov_pkg::t_result             o_result
);

    rsov_pkg::t_dp_cmd cmd;
    rsov_pkg::t_dp_sts sts;

    rsov_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_strobe (o_valid)
    );

    rsov_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_result    (o_result)
    );

endmodule

@@ hdl/rsov_checker.sv @@
// Port-level checks for the outlier vote unit, bound to the top level.
// Depends on rsov_pkg and redundant_sensor_outlier_vote_unit_defines.svh.
`include "redundant_sensor_outlier_vote_unit_defines.svh"

module rsov_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_valid,
    input rsov_pkg::t_result             o_result
);

    logic is_none;
    logic is_all_out;
    logic none_clear;
    logic all_out_ok;

    assign is_none    = o_valid && (o_result.vote_status == rsov_pkg::ST_NONE_VALID);
    assign is_all_out = o_valid && (o_result.vote_status == rsov_pkg::ST_ALL_OUTLIERS);
    assign none_clear = (o_result.fused_temp == '0) && (o_result.valid_count == '0) &&
                        (o_result.outlier_mask == '0);
    assign all_out_ok = (o_result.valid_count == '0) &&
                        ($countones(o_result.outlier_mask) >= 2);

    `RSOV_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")

    `RSOV_ASSERT_IMP(a_strobe_in_work, o_valid, busy, "result strobe with no item in work")

    `RSOV_ASSERT_NXT(a_single_strobe, o_valid, !o_valid && !busy, "more than one result per item")

    `RSOV_ASSERT_IMP(a_none_valid, is_none, none_clear, "none-valid result not cleared")

    `RSOV_ASSERT_IMP(a_all_outliers, is_all_out, all_out_ok, "all-outliers result inconsistent")

endmodule

bind redundant_sensor_outlier_vote_unit rsov_checker u_rsov_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_result    (o_result)
);
